// ----- rtl/core/mtc_pkg.sv -----
// Package for the magnetometer trim compensation block.
// Holds widths, constants, register indexes and shared types.
// No dependencies.
`default_nettype none

package mtc_pkg;

   // Fraction bits of the milligauss outputs.
   localparam int OUT_FRAC_BITS = 4;

   localparam int IN_W   = 16;
   localparam int OUT_W  = 24;
   localparam int AXIS_W = 44;
   localparam int CSR_W  = 48;

   // Pipelined restoring divider geometry.
   localparam int DIV_QBITS = 30;
   localparam int DIV_DBITS = 36;
   localparam int DIV_NBITS = DIV_QBITS + DIV_DBITS;

   // Rounding and scaling of the X/Y result.
   localparam int XY_SHIFT = 31 - OUT_FRAC_BITS;
   localparam logic signed [65:0] XY_ROUND = 66'sd1 <<< (30 - OUT_FRAC_BITS);
   localparam logic [78:0] XY_SAT = 79'd1 << 58;

   // Z scale: microtesla to milligauss with the output fraction bits folded in.
   localparam int Z_SCALE = 5120 * (2 ** OUT_FRAC_BITS);

   // Overflow sentinels of the raw axis values.
   localparam logic [12:0] XY_OVF = 13'h1000;
   localparam logic [14:0] Z_OVF  = 15'h4000;

   localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
   localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

   typedef enum logic [2:0] {
      CSR_XY_TRIM = 3'd0,
      CSR_Z_LOW   = 3'd1,
      CSR_Z_HIGH  = 3'd2,
      CSR_XYZ1    = 3'd3,
      CSR_MOUNT   = 3'd4
   } csr_index_type;

   // Items that ride alongside the two dividers.
   typedef struct packed {
      logic               x_zero;
      logic               y_zero;
      logic signed [21:0] px;
      logic signed [21:0] py;
      logic               z_zero;
      logic               z_ovf;
      logic               z_neg;
   } div_side_type;

endpackage

`default_nettype wire

// ----- rtl/core/magnetometer_trim_compensation_unit.sv -----
// Top level of the magnetometer trim compensation block.
// Depends on mtc_pkg and mtc_div.
`default_nettype none

// Usage:
// Configuration is written through csr_write_enable, csr_index and
// csr_write_data while no item is in flight: index 0 holds the X/Y trims,
// 1 and 2 the Z trims, 3 the reference resistance and 4 the mounting
// orientation. All registers clear to zero at reset.
// An item (four raw sensor words) is accepted at an edge where start is high
// and busy is low. busy stays low, so an item may enter in every cycle.
// Each item gives one result: rsp_valid is high for exactly one cycle with
// the three board axis fields in milligauss, four fraction bits, saturated.
// The result strobe rises once the item has passed the whole pipeline: five stages
// form the Z numerator and denominator, two 30-stage dividers run side by
// side (one quotient bit per stage), six stages finish the X/Y polynomial,
// gain product and rounding, and one stage maps and saturates the axes.
// Throughput is one item per cycle. Results are not held: the receiver must
// take each one in the cycle it is shown. Synchronous reset drops any items
// still in the pipeline.

module magnetometer_trim_compensation_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic [mtc_pkg::IN_W-1:0]          req_x_word,
   input  wire logic [mtc_pkg::IN_W-1:0]          req_y_word,
   input  wire logic [mtc_pkg::IN_W-1:0]          req_z_word,
   input  wire logic [mtc_pkg::IN_W-1:0]          req_r_word,
   output logic                                   rsp_valid,
   output logic signed [mtc_pkg::OUT_W-1:0]       rsp_field_x,
   output logic signed [mtc_pkg::OUT_W-1:0]       rsp_field_y,
   output logic signed [mtc_pkg::OUT_W-1:0]       rsp_field_z,
   input  wire logic                              csr_write_enable,
   input  wire logic [2:0]                        csr_index,
   input  wire logic [mtc_pkg::CSR_W-1:0]         csr_write_data
);

   localparam int QB = mtc_pkg::DIV_QBITS;
   localparam int AW = mtc_pkg::AXIS_W;

   // ---------------------------------------------------------------- config
   logic [47:0] xy_trim_ff;
   logic [31:0] z_low_ff;
   logic [31:0] z_high_ff;
   logic [15:0] xyz1_ff;
   logic [2:0]  mount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xy_trim_ff <= '0;
         z_low_ff   <= '0;
         z_high_ff  <= '0;
         xyz1_ff    <= '0;
         mount_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mtc_pkg::CSR_XY_TRIM: xy_trim_ff <= csr_write_data[47:0];
            mtc_pkg::CSR_Z_LOW:   z_low_ff   <= csr_write_data[31:0];
            mtc_pkg::CSR_Z_HIGH:  z_high_ff  <= csr_write_data[31:0];
            mtc_pkg::CSR_XYZ1:    xyz1_ff    <= csr_write_data[15:0];
            mtc_pkg::CSR_MOUNT:   mount_ff   <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   logic signed [7:0]  trim_x1, trim_y1, trim_x2, trim_y2, trim_xy2;
   logic        [7:0]  trim_xy1;
   logic        [15:0] trim_z1;
   logic signed [15:0] trim_z2, trim_z3, trim_z4;

   assign trim_x1  = $signed(xy_trim_ff[7:0]);
   assign trim_y1  = $signed(xy_trim_ff[15:8]);
   assign trim_x2  = $signed(xy_trim_ff[23:16]);
   assign trim_y2  = $signed(xy_trim_ff[31:24]);
   assign trim_xy2 = $signed(xy_trim_ff[39:32]);
   assign trim_xy1 = xy_trim_ff[47:40];
   assign trim_z1  = z_low_ff[15:0];
   assign trim_z2  = $signed(z_low_ff[31:16]);
   assign trim_z3  = $signed(z_high_ff[15:0]);
   assign trim_z4  = $signed(z_high_ff[31:16]);

   assign busy = 1'b0;

   // ---------------------------------------------------------------- stage 1
   logic               s1_valid_ff;
   logic signed [12:0] s1_rx_ff, s1_ry_ff;
   logic signed [14:0] s1_rz_ff;
   logic        [15:0] s1_r_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start & ~busy;
      end
   end

   always_ff @(posedge clock) begin
      s1_rx_ff <= $signed(req_x_word[15:3]);
      s1_ry_ff <= $signed(req_y_word[15:3]);
      s1_rz_ff <= $signed(req_z_word[15:1]);
      // The resistance is sign extended from 14 bits and then read as unsigned.
      s1_r_ff  <= {req_r_word[15], req_r_word[15], req_r_word[15:2]};
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [9:0]  k2p_x, k2p_y;
   logic signed [22:0] px_full, py_full;
   logic signed [16:0] r_m_xyz;
   logic signed [32:0] z3p_in;
   logic        [31:0] z1p_in;
   logic               r_bad;

   always_comb begin
      k2p_x   = $signed({{2{trim_x2[7]}}, trim_x2}) + 10'sd160;
      k2p_y   = $signed({{2{trim_y2[7]}}, trim_y2}) + 10'sd160;
      px_full = s1_rx_ff * k2p_x;
      py_full = s1_ry_ff * k2p_y;
      r_m_xyz = $signed({1'b0, s1_r_ff}) - $signed({1'b0, xyz1_ff});
      z3p_in  = trim_z3 * r_m_xyz;
      z1p_in  = trim_z1 * s1_r_ff;
      r_bad   = (s1_r_ff == 16'd0) || (xyz1_ff == 16'd0);
   end

   logic               s2_valid_ff;
   logic signed [14:0] s2_rz_ff;
   logic        [15:0] s2_r_ff;
   logic signed [21:0] s2_px_ff, s2_py_ff;
   logic signed [32:0] s2_z3p_ff;
   logic        [31:0] s2_z1p_ff;
   logic               s2_x_zero_ff, s2_y_zero_ff, s2_z_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_rz_ff     <= s1_rz_ff;
      s2_r_ff      <= s1_r_ff;
      s2_px_ff     <= px_full[21:0];
      s2_py_ff     <= py_full[21:0];
      s2_z3p_ff    <= z3p_in;
      s2_z1p_ff    <= z1p_in;
      s2_x_zero_ff <= (s1_rx_ff == mtc_pkg::XY_OVF) || r_bad;
      s2_y_zero_ff <= (s1_ry_ff == mtc_pkg::XY_OVF) || r_bad;
      s2_z_zero_ff <= (s1_rz_ff == mtc_pkg::Z_OVF) || r_bad ||
                      (trim_z1 == 16'd0) || (trim_z2 == 16'sd0);
   end

   // ---------------------------------------------------------------- stage 3
   logic signed [16:0] zdiff;
   logic signed [34:0] n_in;
   logic signed [33:0] d_in;

   always_comb begin
      zdiff = $signed({{2{s2_rz_ff[14]}}, s2_rz_ff}) - $signed({trim_z4[15], trim_z4});
      n_in  = $signed({zdiff[16], zdiff, 17'b0})
              - $signed({{2{s2_z3p_ff[32]}}, s2_z3p_ff});
      d_in  = $signed({{3{trim_z2[15]}}, trim_z2, 15'b0}) + $signed({2'b00, s2_z1p_ff});
   end

   logic               s3_valid_ff;
   logic        [15:0] s3_r_ff;
   logic signed [21:0] s3_px_ff, s3_py_ff;
   logic signed [34:0] s3_n_ff;
   logic signed [33:0] s3_d_ff;
   logic               s3_x_zero_ff, s3_y_zero_ff, s3_z_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s3_r_ff      <= s2_r_ff;
      s3_px_ff     <= s2_px_ff;
      s3_py_ff     <= s2_py_ff;
      s3_n_ff      <= n_in;
      s3_d_ff      <= d_in;
      s3_x_zero_ff <= s2_x_zero_ff;
      s3_y_zero_ff <= s2_y_zero_ff;
      s3_z_zero_ff <= s2_z_zero_ff;
   end

   // ---------------------------------------------------------------- stage 4
   logic signed [57:0] n2;
   logic signed [57:0] n2s;
   logic signed [33:0] dm_signed;
   logic signed [59:0] num_in;

   always_comb begin
      n2 = $signed({{23{s3_n_ff[34]}}, s3_n_ff}) * $signed(58'(mtc_pkg::Z_SCALE));
      // A negative denominator flips both signs so the divisor is positive.
      n2s       = s3_d_ff[33] ? -n2 : n2;
      dm_signed = s3_d_ff[33] ? -s3_d_ff : s3_d_ff;
      num_in    = $signed({{2{n2s[57]}}, n2s[56:0], 1'b0}) + $signed({26'b0, dm_signed});
   end

   logic               s4_valid_ff;
   logic        [15:0] s4_r_ff;
   logic signed [21:0] s4_px_ff, s4_py_ff;
   logic signed [59:0] s4_num_ff;
   logic        [33:0] s4_dm_ff;
   logic               s4_x_zero_ff, s4_y_zero_ff, s4_z_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s4_r_ff      <= s3_r_ff;
      s4_px_ff     <= s3_px_ff;
      s4_py_ff     <= s3_py_ff;
      s4_num_ff    <= num_in;
      s4_dm_ff     <= dm_signed;
      s4_x_zero_ff <= s3_x_zero_ff;
      s4_y_zero_ff <= s3_y_zero_ff;
      s4_z_zero_ff <= s3_z_zero_ff;
   end

   // ---------------------------------------------------------------- stage 5
   logic [59:0] num_mag;
   logic [34:0] den;
   logic        z_ovf_in;

   always_comb begin
      num_mag  = s4_num_ff[59] ? 60'(-s4_num_ff) : 60'(s4_num_ff);
      den      = {s4_dm_ff, 1'b0};
      // Quotients beyond the divider's range only need to saturate later.
      z_ovf_in = {5'b0, num_mag[59:30]} >= den;
   end

   logic                               s5_valid_ff;
   logic        [15:0]                 s5_r_ff;
   logic        [mtc_pkg::DIV_NBITS-1:0] s5_zdvd_ff;
   logic        [mtc_pkg::DIV_DBITS-1:0] s5_zden_ff;
   mtc_pkg::div_side_type              s5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s5_r_ff           <= s4_r_ff;
      s5_zdvd_ff        <= {6'b0, num_mag};
      s5_zden_ff        <= {1'b0, den};
      s5_side_ff.x_zero <= s4_x_zero_ff;
      s5_side_ff.y_zero <= s4_y_zero_ff;
      s5_side_ff.px     <= s4_px_ff;
      s5_side_ff.py     <= s4_py_ff;
      s5_side_ff.z_zero <= s4_z_zero_ff || (s4_dm_ff == 34'd0);
      s5_side_ff.z_ovf  <= z_ovf_in;
      s5_side_ff.z_neg  <= s4_num_ff[59];
   end

   // ---------------------------------------------------------------- dividers
   logic [mtc_pkg::DIV_NBITS-1:0] xy_dividend;
   logic [mtc_pkg::DIV_DBITS-1:0] xy_divisor;
   logic                          xy_div_valid, z_div_valid;
   logic [QB-1:0]                 xy_quot, z_quot;
   logic                          xy_rem_nz, z_rem_nz;

   assign xy_dividend = {36'b0, xyz1_ff, 14'b0};
   assign xy_divisor  = {20'b0, s5_r_ff};

   mtc_div u_xy_div (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s5_valid_ff),
      .in_dividend     (xy_dividend),
      .in_divisor      (xy_divisor),
      .out_valid       (xy_div_valid),
      .out_quotient    (xy_quot),
      .out_rem_nonzero (xy_rem_nz)
   );

   mtc_div u_z_div (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (s5_valid_ff),
      .in_dividend     (s5_zdvd_ff),
      .in_divisor      (s5_zden_ff),
      .out_valid       (z_div_valid),
      .out_quotient    (z_quot),
      .out_rem_nonzero (z_rem_nz)
   );

   mtc_pkg::div_side_type side_ff [QB];

   always_ff @(posedge clock) begin
      side_ff[0] <= s5_side_ff;
      for (int i = 1; i < QB; i++) begin
         side_ff[i] <= side_ff[i-1];
      end
   end

   mtc_pkg::div_side_type side_out;
   assign side_out = side_ff[QB-1];

   // ---------------------------------------------------------------- stage 6
   logic signed [30:0] t_in;
   logic        [30:0] z_mag;
   logic signed [31:0] zq_in;

   always_comb begin
      t_in = $signed({1'b0, xy_quot}) - 31'sd16384;
      // Floor division of a negative numerator rounds the magnitude up.
      z_mag = side_out.z_ovf ? 31'h4000_0000
                             : {1'b0, z_quot} + {30'b0, side_out.z_neg & z_rem_nz};
      if (side_out.z_zero) begin
         zq_in = '0;
      end else if (side_out.z_neg) begin
         zq_in = -$signed({1'b0, z_mag});
      end else begin
         zq_in = $signed({1'b0, z_mag});
      end
   end

   logic               s6_valid_ff;
   logic signed [30:0] s6_t_ff;
   logic signed [31:0] s6_zq_ff;
   logic signed [21:0] s6_px_ff, s6_py_ff;
   logic               s6_x_zero_ff, s6_y_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else begin
         s6_valid_ff <= xy_div_valid & z_div_valid;
      end
   end

   always_ff @(posedge clock) begin
      s6_t_ff      <= t_in;
      s6_zq_ff     <= zq_in;
      s6_px_ff     <= side_out.px;
      s6_py_ff     <= side_out.py;
      s6_x_zero_ff <= side_out.x_zero;
      s6_y_zero_ff <= side_out.y_zero;
   end

   // ---------------------------------------------------------------- stage 7
   logic signed [61:0] tt_in;
   logic signed [39:0] xy1t_in;

   always_comb begin
      tt_in   = s6_t_ff * s6_t_ff;
      xy1t_in = $signed({1'b0, trim_xy1}) * s6_t_ff;
   end

   logic               s7_valid_ff;
   logic signed [61:0] s7_tt_ff;
   logic signed [39:0] s7_xy1t_ff;
   logic signed [31:0] s7_zq_ff;
   logic signed [21:0] s7_px_ff, s7_py_ff;
   logic               s7_x_zero_ff, s7_y_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_valid_ff <= 1'b0;
      end else begin
         s7_valid_ff <= s6_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s7_tt_ff     <= tt_in;
      s7_xy1t_ff   <= xy1t_in;
      s7_zq_ff     <= s6_zq_ff;
      s7_px_ff     <= s6_px_ff;
      s7_py_ff     <= s6_py_ff;
      s7_x_zero_ff <= s6_x_zero_ff;
      s7_y_zero_ff <= s6_y_zero_ff;
   end

   // ---------------------------------------------------------------- stage 8
   logic signed [47:0] tt14;
   logic signed [57:0] a_in;

   always_comb begin
      tt14 = $signed(s7_tt_ff[61:14]);
      a_in = trim_xy2 * tt14 + $signed({{18{s7_xy1t_ff[39]}}, s7_xy1t_ff})
             + 58'sd4194304;
   end

   logic               s8_valid_ff;
   logic signed [57:0] s8_a_ff;
   logic signed [31:0] s8_zq_ff;
   logic signed [21:0] s8_px_ff, s8_py_ff;
   logic               s8_x_zero_ff, s8_y_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s8_valid_ff <= 1'b0;
      end else begin
         s8_valid_ff <= s7_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s8_a_ff      <= a_in;
      s8_zq_ff     <= s7_zq_ff;
      s8_px_ff     <= s7_px_ff;
      s8_py_ff     <= s7_py_ff;
      s8_x_zero_ff <= s7_x_zero_ff;
      s8_y_zero_ff <= s7_y_zero_ff;
   end

   // ---------------------------------------------------------------- stage 9
   logic [56:0] a_abs;
   logic [21:0] px_abs_w, py_abs_w;
   logic [20:0] px_abs, py_abs;
   logic [49:0] plx_in, ply_in;
   logic [48:0] phx_in, phy_in;

   always_comb begin
      a_abs    = s8_a_ff[57] ? 57'(-s8_a_ff) : 57'(s8_a_ff);
      px_abs_w = s8_px_ff[21] ? 22'(-s8_px_ff) : 22'(s8_px_ff);
      py_abs_w = s8_py_ff[21] ? 22'(-s8_py_ff) : 22'(s8_py_ff);
      px_abs   = px_abs_w[20:0];
      py_abs   = py_abs_w[20:0];
      // The gain product is split into two partial products on halves of |A|.
      plx_in   = px_abs * a_abs[28:0];
      phx_in   = px_abs * a_abs[56:29];
      ply_in   = py_abs * a_abs[28:0];
      phy_in   = py_abs * a_abs[56:29];
   end

   logic               s9_valid_ff;
   logic        [49:0] s9_plx_ff, s9_ply_ff;
   logic        [48:0] s9_phx_ff, s9_phy_ff;
   logic               s9_negx_ff, s9_negy_ff;
   logic signed [31:0] s9_zq_ff;
   logic               s9_x_zero_ff, s9_y_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s9_valid_ff <= 1'b0;
      end else begin
         s9_valid_ff <= s8_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s9_plx_ff    <= plx_in;
      s9_phx_ff    <= phx_in;
      s9_ply_ff    <= ply_in;
      s9_phy_ff    <= phy_in;
      s9_negx_ff   <= s8_px_ff[21] ^ s8_a_ff[57];
      s9_negy_ff   <= s8_py_ff[21] ^ s8_a_ff[57];
      s9_zq_ff     <= s8_zq_ff;
      s9_x_zero_ff <= s8_x_zero_ff;
      s9_y_zero_ff <= s8_y_zero_ff;
   end

   // ---------------------------------------------------------------- stage 10
   logic [78:0]        magx, magy;
   logic [58:0]        smagx, smagy;
   logic signed [59:0] sx_in, sy_in;

   always_comb begin
      magx  = ({30'b0, s9_phx_ff} << 29) + {29'b0, s9_plx_ff};
      magy  = ({30'b0, s9_phy_ff} << 29) + {29'b0, s9_ply_ff};
      smagx = (magx > mtc_pkg::XY_SAT) ? mtc_pkg::XY_SAT[58:0] : magx[58:0];
      smagy = (magy > mtc_pkg::XY_SAT) ? mtc_pkg::XY_SAT[58:0] : magy[58:0];
      sx_in = s9_negx_ff ? -$signed({1'b0, smagx}) : $signed({1'b0, smagx});
      sy_in = s9_negy_ff ? -$signed({1'b0, smagy}) : $signed({1'b0, smagy});
   end

   logic               s10_valid_ff;
   logic signed [59:0] s10_sx_ff, s10_sy_ff;
   logic signed [31:0] s10_zq_ff;
   logic               s10_x_zero_ff, s10_y_zero_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s10_valid_ff <= 1'b0;
      end else begin
         s10_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s10_sx_ff     <= sx_in;
      s10_sy_ff     <= sy_in;
      s10_zq_ff     <= s9_zq_ff;
      s10_x_zero_ff <= s9_x_zero_ff;
      s10_y_zero_ff <= s9_y_zero_ff;
   end

   // ---------------------------------------------------------------- stage 11
   logic signed [65:0] sumx, sumy, totx, toty, shx, shy;

   always_comb begin
      sumx = $signed({{6{s10_sx_ff[59]}}, s10_sx_ff})
             + $signed({{28{trim_x1[7]}}, trim_x1, 30'b0});
      sumy = $signed({{6{s10_sy_ff[59]}}, s10_sy_ff})
             + $signed({{28{trim_y1[7]}}, trim_y1, 30'b0});
      // Times ten as two shifted copies, then round half up before the floor shift.
      totx = (sumx <<< 3) + (sumx <<< 1) + mtc_pkg::XY_ROUND;
      toty = (sumy <<< 3) + (sumy <<< 1) + mtc_pkg::XY_ROUND;
      shx  = totx >>> mtc_pkg::XY_SHIFT;
      shy  = toty >>> mtc_pkg::XY_SHIFT;
   end

   logic               s11_valid_ff;
   logic signed [AW-1:0] s11_mx_ff, s11_my_ff, s11_mz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s11_valid_ff <= 1'b0;
      end else begin
         s11_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s11_mx_ff <= s10_x_zero_ff ? '0 : shx[AW-1:0];
      s11_my_ff <= s10_y_zero_ff ? '0 : shy[AW-1:0];
      s11_mz_ff <= $signed({{(AW - 32){s10_zq_ff[31]}}, s10_zq_ff});
   end

   // ---------------------------------------------------------------- output
   logic signed [AW-1:0] bx, by, bz;

   always_comb begin
      unique case (mount_ff)
         3'd0: begin bx = s11_my_ff;  by = s11_mx_ff;  bz = -s11_mz_ff; end
         3'd1: begin bx = s11_mx_ff;  by = -s11_my_ff; bz = -s11_mz_ff; end
         3'd2: begin bx = -s11_my_ff; by = -s11_mx_ff; bz = -s11_mz_ff; end
         3'd3: begin bx = -s11_mx_ff; by = s11_my_ff;  bz = -s11_mz_ff; end
         3'd4: begin bx = s11_my_ff;  by = -s11_mx_ff; bz = s11_mz_ff;  end
         3'd5: begin bx = s11_mx_ff;  by = s11_my_ff;  bz = s11_mz_ff;  end
         3'd6: begin bx = -s11_my_ff; by = s11_mx_ff;  bz = s11_mz_ff;  end
         3'd7: begin bx = -s11_mx_ff; by = -s11_my_ff; bz = s11_mz_ff;  end
      endcase
   end

   function automatic logic signed [mtc_pkg::OUT_W-1:0] sat_out(
      input logic signed [AW-1:0] v
   );
      logic signed [AW-1:0] hi;
      logic signed [AW-1:0] lo;
      hi = $signed({{(AW - mtc_pkg::OUT_W){1'b0}}, mtc_pkg::OUT_MAX});
      lo = $signed({{(AW - mtc_pkg::OUT_W){1'b1}}, mtc_pkg::OUT_MIN});
      if (v > hi) begin
         sat_out = mtc_pkg::OUT_MAX;
      end else if (v < lo) begin
         sat_out = mtc_pkg::OUT_MIN;
      end else begin
         sat_out = v[mtc_pkg::OUT_W-1:0];
      end
   endfunction

   logic                              rsp_valid_ff;
   logic signed [mtc_pkg::OUT_W-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s11_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff <= sat_out(bx);
      rsp_y_ff <= sat_out(by);
      rsp_z_ff <= sat_out(bz);
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_field_x = rsp_x_ff;
   assign rsp_field_y = rsp_y_ff;
   assign rsp_field_z = rsp_z_ff;

endmodule

`default_nettype wire

// ----- rtl/core/mtc_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on mtc_pkg for its widths.
`default_nettype none

module mtc_div (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [mtc_pkg::DIV_NBITS-1:0]  in_dividend,
   input  wire logic [mtc_pkg::DIV_DBITS-1:0]  in_divisor,
   output logic                                out_valid,
   output logic [mtc_pkg::DIV_QBITS-1:0]       out_quotient,
   output logic                                out_rem_nonzero
);

   localparam int QB = mtc_pkg::DIV_QBITS;
   localparam int DB = mtc_pkg::DIV_DBITS;

   logic          valid_ff [QB];
   logic [DB-1:0] rem_ff   [QB];
   logic [QB-1:0] acc_ff   [QB];
   logic [DB-1:0] den_ff   [QB];

   logic          valid_in [QB];
   logic [DB-1:0] rem_in   [QB];
   logic [QB-1:0] acc_in   [QB];
   logic [DB-1:0] den_in   [QB];

   genvar k;
   generate
      for (k = 0; k < QB; k++) begin : g_step
         logic          valid_prev;
         logic [DB-1:0] rem_prev;
         logic [QB-1:0] acc_prev;
         logic [DB-1:0] den_prev;
         logic [DB+1:0] diff;
         logic          take;

         if (k == 0) begin : g_first
            // The partial remainder starts with the dividend bits above the quotient.
            assign valid_prev = in_valid;
            assign rem_prev   = in_dividend[mtc_pkg::DIV_NBITS-1:QB];
            assign acc_prev   = in_dividend[QB-1:0];
            assign den_prev   = in_divisor;
         end else begin : g_next
            assign valid_prev = valid_ff[k-1];
            assign rem_prev   = rem_ff[k-1];
            assign acc_prev   = acc_ff[k-1];
            assign den_prev   = den_ff[k-1];
         end

         always_comb begin
            diff = {1'b0, rem_prev, acc_prev[QB-1]} - {2'b00, den_prev};
            take = ~diff[DB+1];
            valid_in[k] = valid_prev;
            den_in[k]   = den_prev;
            rem_in[k]   = take ? diff[DB-1:0] : {rem_prev[DB-2:0], acc_prev[QB-1]};
            // Dividend bits leave at the top while quotient bits enter at the bottom.
            acc_in[k]   = {acc_prev[QB-2:0], take};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else begin
               valid_ff[k] <= valid_in[k];
            end
         end

         always_ff @(posedge clock) begin
            rem_ff[k] <= rem_in[k];
            acc_ff[k] <= acc_in[k];
            den_ff[k] <= den_in[k];
         end
      end
   endgenerate

   assign out_valid       = valid_ff[QB-1];
   assign out_quotient    = acc_ff[QB-1];
   assign out_rem_nonzero = |rem_ff[QB-1];

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking testbench for the magnetometer trim compensation block.
// Depends on mtc_pkg and magnetometer_trim_compensation_unit; a built-in
// predictor computes the compensated board fields of each item.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [23:0] fx;
      logic signed [23:0] fy;
      logic signed [23:0] fz;
   } field_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [15:0] req_x_word = '0, req_y_word = '0, req_z_word = '0, req_r_word = '0;
   logic rsp_valid;
   logic signed [23:0] rsp_field_x, rsp_field_y, rsp_field_z;
   logic csr_write_enable = 1'b0;
   logic [2:0] csr_index = '0;
   logic [47:0] csr_write_data = '0;

   // Trim settings as the predictor sees them.
   logic [47:0] xy_trim = '0;
   logic [31:0] z_low = '0, z_high = '0;
   logic [15:0] xyz1_trim = '0;
   logic [2:0] mount = '0;

   field_set_type expected_fields[$];
   int errors = 0;
   longint cycles = 0;

   magnetometer_trim_compensation_unit uut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd3000000) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
      errors++;
   endtask

   function automatic longint floor_quot(input longint n, input longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q -= 1;
      return q;
   endfunction

   function automatic longint clamp24(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   function automatic longint compensate_xy(input longint m, input longint r,
         input longint ref_r, input longint k1, input longint k2,
         input longint xy1, input longint xy2);
      longint t, a, p, s, tot;
      if (m == -4096 || r == 0 || ref_r == 0) return 0;
      t = ((ref_r <<< 14) / r) - 16384;
      a = xy2 * ((t * t) >>> 14) + xy1 * t + (64'sd256 <<< 14);
      p = m * (k2 + 160);
      if (p == 0 || a == 0) s = 0;
      else if ((a < 0 ? -a : a) > (64'sd1 <<< 58) / (p < 0 ? -p : p))
         s = ((p < 0) != (a < 0)) ? -(64'sd1 <<< 58) : (64'sd1 <<< 58);
      else s = p * a;
      tot = (s + k1 * (64'sd1 <<< 30)) * 10
            + (64'sd1 <<< (30 - mtc_pkg::OUT_FRAC_BITS));
      return floor_quot(tot, 64'sd1 <<< (31 - mtc_pkg::OUT_FRAC_BITS));
   endfunction

   function automatic longint compensate_z(input longint z, input longint r,
         input longint ref_r, input longint z1, input longint z2,
         input longint z3, input longint z4);
      longint n, d;
      if (z == -16384 || r == 0 || ref_r == 0 || z1 == 0 || z2 == 0) return 0;
      n = (z - z4) * 131072 - z3 * (r - ref_r);
      d = z2 * 32768 + z1 * r;
      if (d == 0) return 0;
      n = n * 5120 * (64'sd1 <<< mtc_pkg::OUT_FRAC_BITS);
      if (d < 0) begin
         d = -d;
         n = -n;
      end
      return floor_quot(2 * n + d, 2 * d);
   endfunction

   function automatic field_set_type board_fields(input logic [15:0] xw, yw, zw, rw);
      longint mx, my, mz, bx, by, bz, r, ref_r;
      field_set_type f;
      ref_r = longint'(xyz1_trim);
      r = longint'({{2{rw[15]}}, rw[15:2]});
      mx = compensate_xy(longint'($signed(xw[15:3])), r, ref_r,
         longint'($signed(xy_trim[7:0])), longint'($signed(xy_trim[23:16])),
         longint'(xy_trim[47:40]), longint'($signed(xy_trim[39:32])));
      my = compensate_xy(longint'($signed(yw[15:3])), r, ref_r,
         longint'($signed(xy_trim[15:8])), longint'($signed(xy_trim[31:24])),
         longint'(xy_trim[47:40]), longint'($signed(xy_trim[39:32])));
      mz = compensate_z(longint'($signed(zw[15:1])), r, ref_r, longint'(z_low[15:0]),
         longint'($signed(z_low[31:16])), longint'($signed(z_high[15:0])),
         longint'($signed(z_high[31:16])));
      case (mount)
         3'd0: begin bx = my; by = mx; bz = -mz; end
         3'd1: begin bx = mx; by = -my; bz = -mz; end
         3'd2: begin bx = -my; by = -mx; bz = -mz; end
         3'd3: begin bx = -mx; by = my; bz = -mz; end
         3'd4: begin bx = my; by = -mx; bz = mz; end
         3'd5: begin bx = mx; by = my; bz = mz; end
         3'd6: begin bx = -my; by = mx; bz = mz; end
         default: begin bx = -mx; by = -my; bz = mz; end
      endcase
      f.fx = 24'(clamp24(bx));
      f.fy = 24'(clamp24(by));
      f.fz = 24'(clamp24(bz));
      return f;
   endfunction

   always @(posedge clock) begin
      field_set_type want;
      if (!reset && rsp_valid) begin
         if (expected_fields.size() == 0) begin
            $display("result with no item outstanding");
            errors++;
         end else begin
            want = expected_fields.pop_front();
            if (rsp_field_x !== want.fx) report("field_x", rsp_field_x, want.fx);
            if (rsp_field_y !== want.fy) report("field_y", rsp_field_y, want.fy);
            if (rsp_field_z !== want.fz) report("field_z", rsp_field_z, want.fz);
         end
      end
   end

   // Idle gaps are mostly zero or short, now and then long.
   task automatic idle_gap();
      int n;
      n = $urandom_range(0, 99);
      n = (n < 55) ? 0 : (n < 95) ? $urandom_range(1, 3) : $urandom_range(5, 30);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_item(input logic [15:0] xw, yw, zw, rw, input bit gaps);
      if (gaps) idle_gap();
      start <= 1'b1;
      req_x_word <= xw;
      req_y_word <= yw;
      req_z_word <= zw;
      req_r_word <= rw;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_fields.push_back(board_fields(xw, yw, zw, rw));
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      start <= 1'b0;
      @(posedge clock);
      while (expected_fields.size() != 0 && guard < 10000) begin
         @(posedge clock);
         guard++;
      end
      repeat (50) @(posedge clock);
   endtask

   task automatic write_csr(input mtc_pkg::csr_index_type idx, input logic [47:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         mtc_pkg::CSR_XY_TRIM: xy_trim = value;
         mtc_pkg::CSR_Z_LOW: z_low = value[31:0];
         mtc_pkg::CSR_Z_HIGH: z_high = value[31:0];
         mtc_pkg::CSR_XYZ1: xyz1_trim = value[15:0];
         default: mount = value[2:0];
      endcase
   endtask

   task automatic load_trims(input logic [47:0] xy, input logic [31:0] zl, zh,
         input logic [15:0] ref_r, input logic [2:0] orient);
      write_csr(mtc_pkg::CSR_XY_TRIM, xy);
      write_csr(mtc_pkg::CSR_Z_LOW, {16'h0, zl});
      write_csr(mtc_pkg::CSR_Z_HIGH, {16'h0, zh});
      write_csr(mtc_pkg::CSR_XYZ1, {32'h0, ref_r});
      write_csr(mtc_pkg::CSR_MOUNT, {45'h0, orient});
   endtask

   // Typical trims: xy1 29, xy2 -3, z1 24747, z2 763, xyz1 6615.
   task automatic load_typical(input logic [2:0] orient);
      load_trims(48'h1d_fd_1c_1c_00_00, {16'd763, 16'd24747},
         {16'hffe0, 16'h0010}, 16'd6615, orient);
   endtask

   task automatic test_directed();
      load_typical(3'd5);
      send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 0); // zero resistance
      send_item(16'h7ff8, 16'h8000, 16'h7ffe, 16'h6720, 0);
      send_item(16'h8000, 16'h7ff8, 16'h8000, 16'h6720, 0); // overflow sentinels
      send_item(16'h8008, 16'h8008, 16'h8002, 16'h6720, 0);
      send_item(16'hfff8, 16'h0008, 16'hfffe, 16'hfffc, 0); // negative r
      send_item(16'h1238, 16'hedc8, 16'h4442, 16'h8000, 0);
      send_item(16'h0ff8, 16'h1000, 16'h1000, 16'h0004, 0); // tiny r
      send_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
      send_item(16'h0007, 16'h0007, 16'h0001, 16'h0003, 0); // ignored low bits
      drain();
      // Huge gain drives the X/Y product into saturation.
      load_trims(48'hff_80_7f_7f_7f_80, 32'h8000_ffff, 32'h7fff_8000, 16'hffff, 3'd7);
      send_item(16'h7ff8, 16'h8008, 16'h7ffe, 16'h0004, 0);
      send_item(16'h8008, 16'h7ff8, 16'h8002, 16'h0004, 0);
      send_item(16'h7ff8, 16'h7ff8, 16'h0000, 16'hfffc, 0);
      drain();
      // Zero z1 or z2 clears Z; a zero denominator does too.
      load_trims(48'h00_00_00_00_00_00, 32'h0000_0001, 32'h0000_0000, 16'h0001, 3'd0);
      send_item(16'h1230, 16'h4560, 16'h2222, 16'h0100, 0);
      drain();
      write_csr(mtc_pkg::CSR_Z_LOW, {16'h0, 16'hfffe, 16'h0001}); // d = -2*32768 + 1*r
      send_item(16'h1230, 16'h4560, 16'h2222, 16'h0004, 0); // r = 1
      send_item(16'h1230, 16'h4560, 16'h2222, 16'h0400, 0); // r = 256
      drain();
      write_csr(mtc_pkg::CSR_Z_LOW, {16'h0, 16'hffff, 16'h8000}); // -32768+32768*1 at r=1
      send_item(16'h0008, 16'h0008, 16'h0002, 16'h0004, 0);
      drain();
   endtask

   task automatic test_orientations();
      for (int o = 0; o < 8; o++) begin
         load_typical(o[2:0]);
         for (int i = 0; i < 8; i++)
            send_item(16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom_range(16'h5000, 16'h7000)), 1);
         drain();
      end
   endtask

   task automatic test_random();
      for (int phase = 0; phase < 10; phase++) begin
         if (phase % 3 == 0)
            load_trims(48'({$urandom, $urandom}), $urandom, $urandom, 16'($urandom),
               3'($urandom));
         else
            load_trims({8'($urandom_range(0, 60)), 8'($urandom_range(0, 8) - 4),
               8'($urandom_range(0, 60) - 30), 8'($urandom_range(0, 60) - 30),
               8'($urandom_range(0, 20) - 10), 8'($urandom_range(0, 20) - 10)},
               {16'($urandom_range(0, 2000) - 1000), 16'($urandom_range(20000, 30000))},
               {16'($urandom_range(0, 200) - 100), 16'($urandom_range(0, 200) - 100)},
               16'($urandom_range(5000, 8000)), 3'($urandom));
         for (int i = 0; i < 150; i++) begin
            logic [15:0] rw;
            rw = ($urandom_range(0, 9) < 8) ? 16'($urandom_range(16'h5000, 16'h7800))
               : 16'($urandom);
            send_item(16'($urandom), 16'($urandom), 16'($urandom), rw,
               (i % 50) >= 20);
         end
         drain();
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_orientations();
      test_random();
      if (errors == 0 && expected_fields.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/core/mtc_pkg.sv
rtl/core/mtc_div.sv
rtl/core/magnetometer_trim_compensation_unit.sv
bench/testbench.sv
